[src/lfu_cache_table_unit_defines.svh]
// Assertion macros shared by the LFU cache table modules.
// No dependencies.
`ifndef LFU_CACHE_TABLE_UNIT_DEFINES_SVH
`define LFU_CACHE_TABLE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define LCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[src/lct_pkg.sv]
// Shared types and constants for the LFU cache table.
// No dependencies.
package lct_pkg;
   localparam int Entries = 16;
   localparam int IdxW = $clog2(Entries);
   localparam int CntW = $clog2(Entries + 1);
   localparam logic [4:0] MaxSlots = 5'(Entries);

   localparam logic ActGet = 1'b0;
   localparam logic ActPut = 1'b1;

   typedef struct packed {
      logic clear_tbl;
      logic load;
      logic scan_start;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } sts_type;
endpackage

[src/lct_datapath.sv]
// Datapath of the LFU cache table: entry storage, slot scan and write-back.
// Depends on lct_pkg and the assertion macro header.
`include "lfu_cache_table_unit_defines.svh"
module lct_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lct_pkg::cmd_type        cmd,
   output lct_pkg::sts_type        sts,
   input  logic [4:0]              capacity,
   input  logic                    req_action,
   input  logic signed [31:0]      req_key,
   input  logic signed [31:0]      req_value,
   output logic                    rsp_hit,
   output logic signed [31:0]      rsp_read_value,
   output logic                    rsp_evicted,
   output logic signed [31:0]      rsp_evicted_key
);
   logic [lct_pkg::Entries-1:0] valid_ff, valid_in;
   logic [31:0] key_ff   [lct_pkg::Entries];
   logic [31:0] value_ff [lct_pkg::Entries];
   logic [31:0] count_ff [lct_pkg::Entries];
   logic [31:0] stamp_ff [lct_pkg::Entries];
   logic [31:0] clock_ff, clock_in;

   logic        act_ff;
   logic [31:0] rkey_ff, rval_ff;
   logic [4:0]  slots_ff;
   logic [lct_pkg::CntW-1:0] pos_ff, pos_in;
   logic [lct_pkg::IdxW-1:0] pos_idx;
   logic        found_ff, found_in, free_ff, free_in;
   logic [lct_pkg::IdxW-1:0] where_ff, where_in, freei_ff, freei_in, best_ff, best_in;
   logic [31:0] bcnt_ff, bcnt_in, bage_ff, bage_in;

   logic [31:0] cur_age;
   logic        better;

   assign pos_idx = pos_ff[lct_pkg::IdxW-1:0];
   assign cur_age = clock_ff - stamp_ff[pos_idx];
   // The first slot seeds the victim; later slots win only if strictly better.
   assign better = (pos_ff == '0) || (count_ff[pos_idx] < bcnt_ff) ||
                   ((count_ff[pos_idx] == bcnt_ff) && (cur_age > bage_ff));
   assign sts.scan_last = (slots_ff == 5'd0) || (5'(pos_ff) + 5'd1 >= slots_ff);

   always_comb begin
      pos_in   = pos_ff;
      found_in = found_ff;
      where_in = where_ff;
      free_in  = free_ff;
      freei_in = freei_ff;
      best_in  = best_ff;
      bcnt_in  = bcnt_ff;
      bage_in  = bage_ff;
      if (cmd.scan_start) begin
         pos_in   = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
         where_in = '0;
         freei_in = '0;
         best_in  = '0;
      end else if (cmd.scan_step && slots_ff != 5'd0) begin
         pos_in = pos_ff + 1'b1;
         if (valid_ff[pos_idx] && key_ff[pos_idx] == rkey_ff && !found_ff) begin
            found_in = 1'b1;
            where_in = pos_idx;
         end
         if (!valid_ff[pos_idx] && !free_ff) begin
            free_in  = 1'b1;
            freei_in = pos_idx;
         end
         if (better) begin
            best_in = pos_idx;
            bcnt_in = count_ff[pos_idx];
            bage_in = cur_age;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      clock_in = clock_ff;
      if (cmd.clear_tbl) begin
         valid_in = '0;
         clock_in = '0;
      end else if (cmd.commit) begin
         if (found_ff && (act_ff == lct_pkg::ActGet || slots_ff != 5'd0)) begin
            clock_in = clock_ff + 32'd1;
         end else if (act_ff == lct_pkg::ActPut && slots_ff != 5'd0) begin
            clock_in = clock_ff + 32'd1;
            valid_in[free_ff ? freei_ff : best_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         clock_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         clock_ff <= clock_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      found_ff <= found_in;
      where_ff <= where_in;
      free_ff  <= free_in;
      freei_ff <= freei_in;
      best_ff  <= best_in;
      bcnt_ff  <= bcnt_in;
      bage_ff  <= bage_in;
      if (cmd.load) begin
         act_ff   <= req_action;
         rkey_ff  <= req_key;
         rval_ff  <= req_value;
         slots_ff <= (capacity > lct_pkg::MaxSlots) ? lct_pkg::MaxSlots : capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit         <= 1'b0;
         rsp_read_value  <= '0;
         rsp_evicted     <= 1'b0;
         rsp_evicted_key <= '0;
         if (found_ff && act_ff == lct_pkg::ActGet) begin
            rsp_hit        <= 1'b1;
            rsp_read_value <= value_ff[where_ff];
            stamp_ff[where_ff] <= clock_ff;
            if (count_ff[where_ff] != '1) count_ff[where_ff] <= count_ff[where_ff] + 32'd1;
         end else if (act_ff == lct_pkg::ActPut && slots_ff != 5'd0) begin
            if (found_ff) begin
               rsp_hit <= 1'b1;
               value_ff[where_ff] <= rval_ff;
               stamp_ff[where_ff] <= clock_ff;
               if (count_ff[where_ff] != '1) count_ff[where_ff] <= count_ff[where_ff] + 32'd1;
            end else begin
               if (!free_ff) begin
                  rsp_evicted     <= 1'b1;
                  rsp_evicted_key <= key_ff[best_ff];
               end
               key_ff[free_ff ? freei_ff : best_ff]   <= rkey_ff;
               value_ff[free_ff ? freei_ff : best_ff] <= rval_ff;
               count_ff[free_ff ? freei_ff : best_ff] <= 32'd1;
               stamp_ff[free_ff ? freei_ff : best_ff] <= clock_ff;
            end
         end
      end
   end

   `LCT_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear_tbl, valid_ff == '0)
   `LCT_ASSERT_NEXT(a_hit_no_evict, clock, reset, cmd.commit, !(rsp_hit && rsp_evicted))
   `LCT_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.scan_start, cmd.scan_step, cmd.commit}))
endmodule

[src/lct_control.sv]
// Control state machine of the LFU cache table: handshakes and scan sequencing.
// Depends on lct_pkg and the assertion macro header.
`include "lfu_cache_table_unit_defines.svh"
module lct_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_valid,
   output logic             csr_ready,
   output lct_pkg::cmd_type cmd,
   input  lct_pkg::sts_type sts
);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StScan = 2'd1;
   localparam logic [1:0] StDone = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       take;

   // A new request may start while the previous response still waits.
   assign req_ready = (state_ff == StIdle) && !csr_valid;
   assign csr_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.clear_tbl = csr_valid && csr_ready;
      case (state_ff)
         StIdle: begin
            if (take) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = StScan;
            end
         end
         StScan: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = StDone;
         end
         StDone: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LCT_ASSERT_NEXT(a_take_scans, clock, reset, take, state_ff == StScan)
   `LCT_ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff)
   `LCT_ASSERT_IMP(a_no_cfg_busy, clock, reset, cmd.clear_tbl, state_ff == StIdle)
endmodule

[src/lfu_cache_table_unit.sv]
// LFU cache table with oldest-access tie break; one request, one response.
// Each request is loaded, scanned slot by slot and then committed to the response register.
// A new request is taken only after the previous one has been committed.
// A response register holds the result so the next request can begin meanwhile.
// Reset (synchronous, active high) empties the table, clears the clock and capacity.
// A capacity write empties the table as well; capacity above 16 counts as 16.
module lfu_cache_table_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_evicted,
   output logic signed [31:0] rsp_evicted_key,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_capacity
);
   lct_pkg::cmd_type cmd;
   lct_pkg::sts_type sts;
   logic [4:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= '0;
      else if (csr_valid && csr_ready) capacity_ff <= csr_capacity;
   end

   lct_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .csr_valid, .csr_ready, .cmd, .sts
   );

   lct_datapath u_dp (
      .clock, .reset, .cmd, .sts, .capacity(capacity_ff),
      .req_action, .req_key, .req_value,
      .rsp_hit, .rsp_read_value, .rsp_evicted, .rsp_evicted_key
   );
endmodule

[bench/lfu_cache_table_unit_tb.sv]
// Self-checking testbench for lfu_cache_table_unit: a behavioral LFU table predicts each
// response and a checker process compares every response transfer. Depends on lct_pkg.
`timescale 1ns / 100ps

module lfu_cache_table_unit_tb;
   localparam int Slots = 16;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = lct_pkg::ActGet;
   logic signed [31:0] req_key = '0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic signed [31:0] rsp_read_value;
   logic rsp_evicted;
   logic signed [31:0] rsp_evicted_key;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_capacity = '0;

   // Predicted table contents.
   logic        tbl_valid [Slots];
   logic [31:0] tbl_key [Slots];
   logic [31:0] tbl_value [Slots];
   logic [31:0] tbl_count [Slots];
   logic [31:0] tbl_stamp [Slots];
   logic [31:0] access_clock;
   logic [4:0]  cur_capacity;

   lookup_result_type expected_results[$];
   int error_count = 0;
   int cycle_count = 0;
   bit rsp_random_stall = 1'b1;
   bit rsp_hold = 1'b0;
   bit req_random_gaps = 1'b1;
   logic [31:0] key_pool [8];

   always #5 clock = ~clock;

   lfu_cache_table_unit dut (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout", $time);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic flush_table();
      for (int s = 0; s < Slots; s++) begin
         tbl_valid[s] = 1'b0;
         tbl_key[s] = '0;
         tbl_value[s] = '0;
         tbl_count[s] = '0;
         tbl_stamp[s] = '0;
      end
      access_clock = '0;
   endtask

   function automatic void touch_slot(int s);
      if (tbl_count[s] != 32'hFFFF_FFFF) tbl_count[s]++;
      tbl_stamp[s] = access_clock;
      access_clock++;
   endfunction

   function automatic lookup_result_type predict_access(logic act, logic [31:0] k,
                                                        logic [31:0] v);
      lookup_result_type r;
      int slots;
      int where;
      int target;
      int best;
      r = '0;
      slots = (cur_capacity > Slots) ? Slots : int'(cur_capacity);
      where = -1;
      for (int s = 0; s < slots; s++)
         if (where < 0 && tbl_valid[s] && tbl_key[s] == k) where = s;
      if (act == lct_pkg::ActGet) begin
         if (where >= 0) begin
            touch_slot(where);
            r.hit = 1'b1;
            r.read_value = tbl_value[where];
         end
         return r;
      end
      if (slots == 0) return r;
      if (where >= 0) begin
         touch_slot(where);
         tbl_value[where] = v;
         r.hit = 1'b1;
         return r;
      end
      target = -1;
      for (int s = 0; s < slots; s++)
         if (target < 0 && !tbl_valid[s]) target = s;
      if (target < 0) begin
         best = 0;
         for (int s = 1; s < slots; s++)
            if (tbl_count[s] < tbl_count[best] ||
                (tbl_count[s] == tbl_count[best] &&
                 (access_clock - tbl_stamp[s]) > (access_clock - tbl_stamp[best])))
               best = s;
         target = best;
         r.evicted = 1'b1;
         r.evicted_key = tbl_key[best];
      end
      tbl_valid[target] = 1'b1;
      tbl_key[target] = k;
      tbl_value[target] = v;
      tbl_count[target] = 32'd1;
      tbl_stamp[target] = access_clock;
      access_clock++;
      return r;
   endfunction

   // Receiver side: random stall bursts, plus a long hold when requested.
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (rsp_random_stall && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response transfer", $time);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_hit !== exp_r.hit) begin
               $display("%0t: hit expected %0h actual %0h", $time, exp_r.hit, rsp_hit);
               error_count++;
            end
            if (rsp_read_value !== exp_r.read_value) begin
               $display("%0t: read_value expected %0h actual %0h", $time,
                        exp_r.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_evicted !== exp_r.evicted) begin
               $display("%0t: evicted expected %0h actual %0h", $time,
                        exp_r.evicted, rsp_evicted);
               error_count++;
            end
            if (rsp_evicted_key !== exp_r.evicted_key) begin
               $display("%0t: evicted_key expected %0h actual %0h", $time,
                        exp_r.evicted_key, rsp_evicted_key);
               error_count++;
            end
         end
      end
   end

   // Valid stays high from one transfer to the next unless an idle gap is drawn.
   task automatic send_request(logic act, logic [31:0] k, logic [31:0] v);
      if (req_random_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_access(act, k, v));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // Capacity writes happen only with the table idle; a write empties it.
   task automatic write_capacity(logic [4:0] cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_capacity = cap;
      flush_table();
   endtask

   task automatic test_capacity_zero();
      write_capacity(5'd0);
      send_request(lct_pkg::ActPut, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(lct_pkg::ActGet, 32'h7FFF_FFFF, 32'h0);
      send_request(lct_pkg::ActPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_directed_eviction();
      write_capacity(5'd2);
      send_request(lct_pkg::ActPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lct_pkg::ActPut, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(lct_pkg::ActGet, 32'hFFFF_FFFF, 32'h1234);
      send_request(lct_pkg::ActPut, 32'h0, 32'h0);
      send_request(lct_pkg::ActGet, 32'h8000_0000, 32'h0);
      send_request(lct_pkg::ActPut, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      send_request(lct_pkg::ActPut, 32'h1, 32'h1);
      send_request(lct_pkg::ActGet, 32'hFFFF_FFFF, 32'h0);
      // Equal counts fall back to the oldest access.
      write_capacity(5'd3);
      for (int i = 0; i < 3; i++) send_request(lct_pkg::ActPut, 32'(i + 10), 32'(i));
      send_request(lct_pkg::ActPut, 32'd20, 32'd20);
      send_request(lct_pkg::ActPut, 32'd21, 32'd21);
      // Capacity above the table size behaves as a full table.
      write_capacity(5'd31);
      for (int i = 0; i < 17; i++) send_request(lct_pkg::ActPut, 32'(i), 32'(~i));
   endtask

   task automatic random_phase(logic [4:0] cap, int n);
      logic [31:0] k;
      write_capacity(cap);
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      for (int i = 0; i < n; i++) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
         send_request(1'($urandom_range(0, 1)), k, $urandom());
      end
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      write_capacity(5'd4);
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            for (int i = 0; i < 20; i++)
               send_request(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, 7)],
                            $urandom());
         end
      join
      wait_drained();
   endtask

   task automatic test_random();
      random_phase(5'd1, 150);
      random_phase(5'd16, 450);
      random_phase(5'($urandom_range(2, 15)), 400);
      random_phase(5'd5, 300);
      rsp_random_stall = 1'b0;
      req_random_gaps = 1'b0;
      random_phase(5'd8, 400);
   endtask

   initial begin
      flush_table();
      cur_capacity = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_capacity_zero();
      test_directed_eviction();
      test_backpressure();
      test_random();
      wait_drained();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[lfu_cache_table_unit.f]
+incdir+src
src/lct_pkg.sv
src/lct_datapath.sv
src/lct_control.sv
src/lfu_cache_table_unit.sv
bench/lfu_cache_table_unit_tb.sv
